// ===== sv/dyadic_pattern_matrix_multiply_macros.svh =====
// Assertion macros for the dyadic pattern matrix multiply block.
// Needs only a clock and an active-low reset at the point of use.
`ifndef DYADIC_PATTERN_MATRIX_MULTIPLY_MACROS_SVH
`define DYADIC_PATTERN_MATRIX_MULTIPLY_MACROS_SVH
`ifndef ASSERT_OFF
`define DPMM_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DPMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DPMM_ASSERT(lbl, clk, rstn, prop, msg)
`define DPMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== sv/dpmm_pkg.sv =====
// Shared types, codes and the control-store program of the matrix multiply.
// No dependencies.
package dpmm_pkg;

	localparam logic [1:0] MODE_LOAD_A  = 2'd0;
	localparam logic [1:0] MODE_LOAD_B  = 2'd1;
	localparam logic [1:0] MODE_COMPUTE = 2'd2;

	localparam logic [1:0] STEP_IDLE   = 2'd0;
	localparam logic [1:0] STEP_LOOP   = 2'd1;
	localparam logic [1:0] STEP_DRAIN1 = 2'd2;
	localparam logic [1:0] STEP_DRAIN2 = 2'd3;

	// jump conditions; when false the step counter advances by one
	typedef enum logic [1:0] {
		COND_NEVER   = 2'd0,
		COND_ALWAYS  = 2'd1,
		COND_NO_REQ  = 2'd2,
		COND_MORE    = 2'd3
	} cond_t;

	typedef struct packed {
		logic       busy;
		logic       issue;
		logic       init;
		cond_t      cond;
		logic [1:0] target;
	} ctl_word_t;

	typedef struct packed {
		logic busy;
		logic issue;
		logic init;
	} seq_ctl_t;

	typedef struct packed {
		logic compute_req;
		logic more;
	} seq_stat_t;

	function automatic ctl_word_t ucode(input logic [1:0] step);
		ctl_word_t w;
		case (step)
			STEP_IDLE:   w = '{busy: 1'b0, issue: 1'b0, init: 1'b1,
				cond: COND_NO_REQ, target: STEP_IDLE};
			STEP_LOOP:   w = '{busy: 1'b1, issue: 1'b1, init: 1'b0,
				cond: COND_MORE, target: STEP_LOOP};
			STEP_DRAIN1: w = '{busy: 1'b1, issue: 1'b0, init: 1'b0,
				cond: COND_NEVER, target: STEP_IDLE};
			STEP_DRAIN2: w = '{busy: 1'b1, issue: 1'b0, init: 1'b0,
				cond: COND_ALWAYS, target: STEP_IDLE};
			default:     w = '{busy: 1'b0, issue: 1'b0, init: 1'b1,
				cond: COND_ALWAYS, target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/dpmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/dpmm_seq.sv =====
// Microcoded sequencer: step counter over the control store in dpmm_pkg.
// Depends on dpmm_pkg.
module dpmm_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  dpmm_pkg::seq_stat_t stat,
	output dpmm_pkg::seq_ctl_t  ctl
);

	logic [1:0]          step_q;
	dpmm_pkg::ctl_word_t word;
	logic                take;

	assign word = dpmm_pkg::ucode(step_q);

	always_comb begin
		case (word.cond)
			dpmm_pkg::COND_NEVER:  take = 1'b0;
			dpmm_pkg::COND_ALWAYS: take = 1'b1;
			dpmm_pkg::COND_NO_REQ: take = !stat.compute_req;
			dpmm_pkg::COND_MORE:   take = stat.more;
			default:               take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dpmm_pkg::STEP_IDLE;
		end else if (take) begin
			step_q <= word.target;
		end else begin
			step_q <= step_q + 2'd1;
		end
	end

	assign ctl.busy  = word.busy;
	assign ctl.issue = word.issue;
	assign ctl.init  = word.init;

endmodule

// ===== sv/dyadic_pattern_matrix_multiply.sv =====
// Top level of the dyadic pattern matrix multiply: row stores, MAC datapath.
// Depends on dpmm_pkg, dpmm_ram, dpmm_seq and the assertion macro header.
//
// A load word (mode 0 or 1) is taken whenever busy is low. A compute word
// holds busy high till its n*n products, n being the order in use, are summed:
// one multiply-accumulate per cycle through the single 16x16 multiplier,
// fed by one read port on each row store, while the sequencer steps k, then
// m. Results come one per m, each on the result ports for one cycle with
// result_strobe high; they cannot be held off, so the receiver must take every
// strobe. The last result (last_entry high) shows in the cycle busy falls.
// Write order_log2 only while busy is low and no result is still due.
`include "dyadic_pattern_matrix_multiply_macros.svh"

module dyadic_pattern_matrix_multiply #(
	parameter int MAX_ORDER = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [3:0]         position,
	input  logic signed [15:0] element_value,
	output logic               result_strobe,
	output logic [3:0]         result_index,
	output logic signed [35:0] result_value,
	output logic               last_entry
);

	localparam int DEPTH = (MAX_ORDER < 16) ? MAX_ORDER : 16;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LIM   = $clog2(DEPTH + 1) - 1;

	logic [2:0]          order_log2_q;
	logic [2:0]          eff_log;
	logic [4:0]          mask_full;
	logic [AW-1:0]       last_k;
	dpmm_pkg::seq_ctl_t  ctl;
	dpmm_pkg::seq_stat_t stat;
	logic                accept;
	logic                in_range;
	logic                we_a, we_b;
	logic [AW-1:0]       k_q, m_q;
	logic                end_row;
	logic [15:0]         a_rd, b_rd;
	logic                vld_s1, eor_s1, last_s1;
	logic [AW-1:0]       m_s1;
	logic                vld_s2, eor_s2, last_s2;
	logic [AW-1:0]       m_s2;
	logic signed [31:0]  prod_s2;
	logic signed [35:0]  acc_q;
	logic signed [35:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_log2_q <= 3'd4;
		end else if (cfg_we) begin
			order_log2_q <= cfg_wdata;
		end
	end

	assign eff_log   = (order_log2_q > 3'(LIM)) ? 3'(LIM) : order_log2_q;
	assign mask_full = (5'd1 << eff_log) - 5'd1;
	assign last_k    = mask_full[AW-1:0];

	assign busy     = ctl.busy;
	assign accept   = start && !busy;
	assign in_range = {1'b0, position} < 5'(DEPTH);
	assign we_a     = accept && (mode == dpmm_pkg::MODE_LOAD_A) && in_range;
	assign we_b     = accept && (mode == dpmm_pkg::MODE_LOAD_B) && in_range;

	assign end_row          = (k_q == last_k);
	assign stat.compute_req = accept && (mode == dpmm_pkg::MODE_COMPUTE);
	assign stat.more        = !(end_row && (m_q == last_k));

	dpmm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	dpmm_ram #(.WIDTH(16), .DEPTH(DEPTH), .AW(AW)) u_a_row (
		.clk   (clk),
		.we    (we_a),
		.waddr (position[AW-1:0]),
		.wdata (element_value),
		.re    (ctl.issue),
		.raddr (k_q),
		.rdata (a_rd)
	);

	dpmm_ram #(.WIDTH(16), .DEPTH(DEPTH), .AW(AW)) u_b_row (
		.clk   (clk),
		.we    (we_b),
		.waddr (position[AW-1:0]),
		.wdata (element_value),
		.re    (ctl.issue),
		.raddr (k_q ^ m_q),
		.rdata (b_rd)
	);

	// k runs fastest; m steps at each row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			m_q <= '0;
		end else if (ctl.init) begin
			k_q <= '0;
			m_q <= '0;
		end else if (ctl.issue) begin
			if (end_row) begin
				k_q <= '0;
				m_q <= m_q + AW'(1);
			end else begin
				k_q <= k_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		eor_s1  <= end_row;
		last_s1 <= end_row && (m_q == last_k);
		m_s1    <= m_q;
		eor_s2  <= eor_s1;
		last_s2 <= last_s1;
		m_s2    <= m_s1;
		prod_s2 <= $signed(a_rd) * $signed(b_rd);
	end

	assign sum = acc_q + 36'(prod_s2);

	always_ff @(posedge clk) begin
		if (ctl.init || (vld_s2 && eor_s2)) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= sum;
		end
		if (vld_s2 && eor_s2) begin
			result_value <= sum;
			result_index <= 4'(m_s2);
			last_entry   <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= vld_s2 && eor_s2;
		end
	end

	`DPMM_ASSERT(a_issue_busy, clk, arst_n, !ctl.issue || busy, "read issued while idle")
	`DPMM_ASSERT_NEXT(a_compute_busy, clk, arst_n, stat.compute_req, busy, "compute not started")
	`DPMM_ASSERT(a_last_idle, clk, arst_n, !(result_strobe && last_entry) || !busy,
		"still busy after final word")
	`DPMM_ASSERT_NEXT(a_more_busy, clk, arst_n, result_strobe && !last_entry, busy,
		"row ended before last word")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for dyadic_pattern_matrix_multiply: loads first rows, fires computes, checks rows.
// Depends on dpmm_pkg and the block's RTL; self-contained otherwise.
module tb;

	localparam int MAX_ORDER = 16;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 300;
	localparam int RANDOM_ITEMS = 320;

	typedef struct {
		logic [1:0]         mode;
		logic [3:0]         pos;
		logic signed [15:0] val;
		bit                 drain_first;
	} op_word_t;

	typedef struct {
		logic [3:0]         index;
		logic signed [35:0] value;
		logic               last;
	} row_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = dpmm_pkg::MODE_LOAD_A;
	logic [3:0] position = '0;
	logic signed [15:0] element_value = '0;
	logic result_strobe;
	logic [3:0] result_index;
	logic signed [35:0] result_value;
	logic last_entry;

	dyadic_pattern_matrix_multiply #(.MAX_ORDER(MAX_ORDER)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.mode(mode),
		.position(position),
		.element_value(element_value),
		.result_strobe(result_strobe),
		.result_index(result_index),
		.result_value(result_value),
		.last_entry(last_entry)
	);

	always #2 clk = ~clk;

	// predictor state
	logic signed [15:0] a_row [MAX_ORDER];
	logic signed [15:0] b_row [MAX_ORDER];
	logic [2:0] order_now = 3'd4;

	op_word_t pending_words[$];
	row_entry_t due_row[$];
	int idle_pct = 0;
	int err_count = 0;

	// stimulus-side record of which entries have been loaded
	bit [15:0] a_done = '0;
	bit [15:0] b_done = '0;
	int gen_count = 0;

	function automatic int eff_log(input logic [2:0] v);
		int lim;
		lim = 0;
		while (lim < 4 && (1 << (lim + 1)) <= MAX_ORDER)
			lim++;
		return (int'(v) > lim) ? lim : int'(v);
	endfunction

	function automatic void take_word(input logic [1:0] md, input logic [3:0] pos,
			input logic signed [15:0] val);
		int n;
		longint acc;
		row_entry_t e;
		if (md == dpmm_pkg::MODE_LOAD_A || md == dpmm_pkg::MODE_LOAD_B) begin
			if (int'(pos) < MAX_ORDER) begin
				if (md == dpmm_pkg::MODE_LOAD_A)
					a_row[pos] = val;
				else
					b_row[pos] = val;
			end
		end else if (md == dpmm_pkg::MODE_COMPUTE) begin
			n = 1 << eff_log(order_now);
			for (int m = 0; m < n; m++) begin
				acc = 0;
				for (int k = 0; k < n; k++)
					acc += longint'(a_row[k]) * longint'(b_row[k ^ m]);
				e.index = 4'(m);
				e.value = 36'(acc);
				e.last = (m == n - 1);
				due_row.push_back(e);
			end
		end
	endfunction

	// driver: one word per handshake, held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= dpmm_pkg::MODE_LOAD_A;
			position <= '0;
			element_value <= '0;
		end else begin : drive
			op_word_t w;
			bit taken;
			bit blocked;
			taken = start && !busy;
			if (taken)
				take_word(mode, position, element_value);
			if (!(start && !taken)) begin
				blocked = 1'b0;
				if (pending_words.size() != 0 && pending_words[0].drain_first)
					// hold until the monitor has popped every due word
					blocked = due_row.size() != 0;
				if (pending_words.size() != 0 && !blocked &&
						$urandom_range(99) >= idle_pct) begin
					w = pending_words.pop_front();
					start <= 1'b1;
					mode <= w.mode;
					position <= w.pos;
					element_value <= w.val;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobe is a result word, checked against the oldest due entry
	always @(posedge clk) begin : check
		row_entry_t e;
		if (arst_n && result_strobe) begin
			if (due_row.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result: index %0d value %0d last %0b",
						result_index, result_value, last_entry);
			end else begin
				e = due_row.pop_front();
				if (result_index !== e.index || result_value !== e.value ||
						last_entry !== e.last) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: exp index %0d value %0d last %0b, got %0d %0d %0b",
							e.index, e.value, e.last, result_index, result_value,
							last_entry);
				end
			end
		end
	end

	task automatic queue_word(input logic [1:0] md, input logic [3:0] pos,
			input logic signed [15:0] val, input bit drain);
		op_word_t w;
		w.mode = md;
		w.pos = pos;
		w.val = val;
		w.drain_first = drain;
		pending_words.push_back(w);
		if (md == dpmm_pkg::MODE_LOAD_A)
			a_done[pos] = 1'b1;
		if (md == dpmm_pkg::MODE_LOAD_B)
			b_done[pos] = 1'b1;
		if (md != MODE_UNUSED)
			gen_count++;
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic bit rows_ready(input int n);
		for (int p = 0; p < n; p++)
			if (!a_done[p] || !b_done[p])
				return 1'b0;
		return 1'b1;
	endfunction

	// both rows, every entry below n, in shuffled order
	task automatic load_rows(input int n);
		int slots[$];
		int idx;
		int s;
		for (int p = 0; p < n; p++) begin
			slots.push_back(p);
			slots.push_back(p + 16);
		end
		while (slots.size() != 0) begin
			idx = $urandom_range(slots.size() - 1);
			s = slots[idx];
			slots.delete(idx);
			queue_word((s >= 16) ? dpmm_pkg::MODE_LOAD_B : dpmm_pkg::MODE_LOAD_A,
				4'(s % 16), pick_value(), 1'b0);
		end
	endtask

	task automatic queue_compute(input bit drain);
		queue_word(dpmm_pkg::MODE_COMPUTE, 4'($urandom), 16'($urandom), drain);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || start || due_row.size() != 0 || busy);
	endtask

	// order may only change once the block has gone quiet
	task automatic write_order(input logic [2:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		order_now = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("dyadic_pattern_matrix_multiply test failed");
		$finish;
	end

	initial begin : stimulus
		logic [2:0] cfg_seq [8];
		logic [2:0] ord;
		int n;
		int phase;
		int kind;
		cfg_seq = '{3'd0, 3'd7, 3'd4, 3'd2, 3'd5, 3'd1, 3'd6, 3'd3};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: order one, extremes, ignored mode, loads past n, drain pause
		write_order(3'd0);
		queue_word(dpmm_pkg::MODE_LOAD_A, 4'd0, 16'sh8000, 1'b0);
		queue_word(dpmm_pkg::MODE_LOAD_B, 4'd0, 16'sh8000, 1'b0);
		queue_word(dpmm_pkg::MODE_COMPUTE, 4'd15, 16'sh7fff, 1'b0);
		queue_word(MODE_UNUSED, 4'd0, 16'sh0000, 1'b0);
		queue_word(MODE_UNUSED, 4'd15, 16'shffff, 1'b0);
		queue_word(dpmm_pkg::MODE_LOAD_A, 4'd0, 16'sh7fff, 1'b0);
		queue_compute(1'b0);
		queue_word(dpmm_pkg::MODE_LOAD_A, 4'd9, 16'shffff, 1'b0);
		queue_word(dpmm_pkg::MODE_LOAD_B, 4'd15, 16'sh7fff, 1'b0);
		queue_compute(1'b1);
		write_order(3'd1);
		queue_word(dpmm_pkg::MODE_LOAD_A, 4'd1, 16'sh7fff, 1'b0);
		queue_word(dpmm_pkg::MODE_LOAD_B, 4'd1, 16'sh8000, 1'b0);
		queue_compute(1'b0);
		queue_word(dpmm_pkg::MODE_LOAD_B, 4'd0, 16'sh7fff, 1'b0);
		queue_compute(1'b0);

		gen_count = 0;
		phase = 0;
		while (gen_count < RANDOM_ITEMS) begin
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 52;
				2: idle_pct = 0;
				default: idle_pct = 13;
			endcase
			if (phase < 8)
				ord = cfg_seq[phase];
			else if ($urandom_range(3) == 0)
				ord = 3'($urandom_range(4, 7));
			else
				ord = 3'($urandom_range(0, 3));
			write_order(ord);
			n = 1 << eff_log(ord);
			for (int j = 0; j < 3; j++) begin
				kind = $urandom_range(9);
				if (!rows_ready(n) && kind != 8)
					kind = 0;
				case (kind)
					6: begin
						// partial reload on top of the current rows
						repeat ($urandom_range(1, 3))
							queue_word(3'($urandom_range(1)) == 0 ?
								dpmm_pkg::MODE_LOAD_A : dpmm_pkg::MODE_LOAD_B,
								4'($urandom_range(n - 1)), pick_value(), 1'b0);
						queue_compute($urandom_range(7) == 0);
					end
					7: begin
						// entries past the order are stored but left out of the sum
						repeat ($urandom_range(1, 4))
							queue_word($urandom_range(1) == 0 ?
								dpmm_pkg::MODE_LOAD_A : dpmm_pkg::MODE_LOAD_B,
								4'($urandom_range(15)), pick_value(), 1'b0);
						if (rows_ready(n))
							queue_compute(1'b0);
					end
					8: begin
						repeat ($urandom_range(1, 3))
							queue_word(MODE_UNUSED, 4'($urandom), 16'($urandom), 1'b0);
						if (rows_ready(n))
							queue_compute(1'b0);
					end
					9: begin
						// broken job: loads with no compute
						repeat ($urandom_range(1, n))
							queue_word($urandom_range(1) == 0 ?
								dpmm_pkg::MODE_LOAD_A : dpmm_pkg::MODE_LOAD_B,
								4'($urandom_range(n - 1)), pick_value(), 1'b0);
					end
					default: begin
						load_rows(n);
						queue_compute($urandom_range(7) == 0);
					end
				endcase
			end
			phase++;
		end

		do
			@(negedge clk);
		while (pending_words.size() != 0 || start);
		while (due_row.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && due_row.size() == 0) begin
			$display("dyadic_pattern_matrix_multiply test passed");
		end else begin
			$display("dyadic_pattern_matrix_multiply test failed");
		end
		$finish;
	end

endmodule
